/* hw/rtl/rlt_pkg.sv */
// shared types, codes and constants for the record lock table
// no dependencies
package rlt_pkg;

   localparam int TABLE_ENTRIES = 128;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam logic [62:0] EOF_MARK = 63'h7FFF_FFFF_FFFF_FFFF;

   localparam logic [1:0] KIND_QUERY   = 2'd0;
   localparam logic [1:0] KIND_SET     = 2'd1;
   localparam logic [1:0] KIND_REL_ALL = 2'd2;
   localparam logic [1:0] KIND_REL_FILE = 2'd3;

   localparam logic [1:0] LT_READ   = 2'd0;
   localparam logic [1:0] LT_WRITE  = 2'd1;
   localparam logic [1:0] LT_UNLOCK = 2'd2;
   localparam logic [1:0] LT_BAD    = 2'd3;

   localparam logic [1:0] ORG_START = 2'd0;
   localparam logic [1:0] ORG_END   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_INVAL = 2'd1;
   localparam logic [1:0] ST_BLOCK = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic        valid;
      logic [31:0] dev;
      logic [63:0] ino;
      logic [31:0] owner;
      logic        is_write;
      logic [62:0] first;
      logic [62:0] last;
   } entry_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] file_dev;
      logic [63:0] file_ino;
      logic [31:0] owner;
      logic [1:0]  lock_type;
      logic [1:0]  origin;
      logic [63:0] region_start;
      logic [63:0] region_len;
      logic [62:0] file_size;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        conflict_found;
      logic        conflict_is_write;
      logic [62:0] conflict_start;
      logic [62:0] conflict_len;
      logic [31:0] conflict_owner;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RESOLVE,
      S_SEEK,
      S_UPDATE
   } state_type;

endpackage

/* hw/rtl/record_lock_table.sv */
// top level of the record lock table: ring of lock slots plus sequencer
// depends on rlt_pkg, rlt_cell, rlt_ctrl
//
// byte-range read/write lock table of TABLE_ENTRIES slots, kept as a ring of
// cells that rotates one slot per cycle while a pass is running, past a
// single processing unit at the head. one request is handled at a time: a
// beat is taken only while idle with no result pending. a range error on a
// query or set, or an undefined type on a set, is answered from the resolve
// state without a ring pass. a query and a release take one ring revolution.
// an unlock also takes one revolution; a read or write set takes a conflict
// pass and then an update pass, or one pass if it would block. the result
// waits in an output register until taken. reset clears every valid bit at
// once, so no clearing sweep is needed.
module record_lock_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_file_dev,
   input  logic [63:0] req_file_ino,
   input  logic [31:0] req_owner,
   input  logic [1:0]  req_lock_type,
   input  logic [1:0]  req_origin,
   input  logic [63:0] req_region_start,
   input  logic [63:0] req_region_len,
   input  logic [62:0] req_file_size,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_conflict_found,
   output logic        rsp_conflict_is_write,
   output logic [62:0] rsp_conflict_start,
   output logic [62:0] rsp_conflict_len,
   output logic [31:0] rsp_conflict_owner
);
   import rlt_pkg::*;

   req_type   req;
   rsp_type   rsp;
   entry_type ring [TABLE_ENTRIES];
   entry_type tail;
   logic      shift;

   // pack the request beat
   assign req.kind = req_kind;
   assign req.file_dev = req_file_dev;
   assign req.file_ino = req_file_ino;
   assign req.owner = req_owner;
   assign req.lock_type = req_lock_type;
   assign req.origin = req_origin;
   assign req.region_start = req_region_start;
   assign req.region_len = req_region_len;
   assign req.file_size = req_file_size;

   rlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .head      (ring[0]),
      .tail      (tail),
      .shift     (shift)
   );

   // cell i takes cell i+1; the last cell takes the processed head slot,
   // so after a full revolution slot order is back in place
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      entry_type d;
      if (i == TABLE_ENTRIES - 1) begin : g_last
         assign d = tail;
      end else begin : g_mid
         assign d = ring[i+1];
      end
      rlt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .d     (d),
         .q     (ring[i])
      );
   end

   // unpack the result beat
   assign rsp_status = rsp.status;
   assign rsp_conflict_found = rsp.conflict_found;
   assign rsp_conflict_is_write = rsp.conflict_is_write;
   assign rsp_conflict_start = rsp.conflict_start;
   assign rsp_conflict_len = rsp.conflict_len;
   assign rsp_conflict_owner = rsp.conflict_owner;

endmodule

/* hw/rtl/rlt_cell.sv */
// one lock slot of the rotating table ring
// depends on rlt_pkg
module rlt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  rlt_pkg::entry_type d,
   output rlt_pkg::entry_type q
);
   import rlt_pkg::*;

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (shift) begin
         entry_ff.valid <= d.valid;
      end
      if (shift) begin
         entry_ff.dev      <= d.dev;
         entry_ff.ino      <= d.ino;
         entry_ff.owner    <= d.owner;
         entry_ff.is_write <= d.is_write;
         entry_ff.first    <= d.first;
         entry_ff.last     <= d.last;
      end
   end

   assign q = entry_ff;

endmodule

/* hw/rtl/rlt_ctrl.sv */
// request sequencer and head-of-ring processing unit
// depends on rlt_pkg
module rlt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rlt_pkg::req_type   req,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rlt_pkg::rsp_type   rsp,
   input  rlt_pkg::entry_type head,
   output rlt_pkg::entry_type tail,
   output logic               shift
);
   import rlt_pkg::*;

   localparam logic signed [65:0] MAX66 = $signed({3'b000, EOF_MARK});

   state_type state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   req_type req_ff;
   logic [62:0] first_ff, first_in, last_ff, last_in;
   logic wr_ff, wr_in, ins_ff, ins_in, done_ins_ff, done_ins_in;
   rsp_type hit_ff, hit_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic signed [65:0] base, st, len, s, e_pos, f_neg, l_neg;
   logic range_ok;
   logic same, own, ovl, drop, last_cnt;

   // range resolution in wide signed arithmetic
   always_comb begin
      base = (req_ff.origin == ORG_END) ? $signed({3'b000, req_ff.file_size}) : '0;
      st = $signed({{2{req_ff.region_start[63]}}, req_ff.region_start});
      len = $signed({{2{req_ff.region_len[63]}}, req_ff.region_len});
      s = base + st;
      e_pos = s + len - 66'sd1;
      f_neg = s + len;
      l_neg = s - 66'sd1;
      range_ok = (req_ff.origin == ORG_START || req_ff.origin == ORG_END)
                 && s >= 66'sd0 && s <= MAX66;
      if (len > 66'sd0 && e_pos > MAX66) range_ok = 1'b0;
      if (len < 66'sd0 && f_neg < 66'sd0) range_ok = 1'b0;
   end

   assign same = head.valid && head.dev == req_ff.file_dev && head.ino == req_ff.file_ino;
   assign own = head.owner == req_ff.owner;
   assign ovl = first_ff <= head.last && head.first <= last_ff;
   assign last_cnt = cnt_ff == IDX_W'(TABLE_ENTRIES - 1);

   always_comb begin
      priority case (req_ff.kind)
         KIND_REL_ALL:  drop = head.valid && own;
         KIND_REL_FILE: drop = same && own;
         default:       drop = same && own && ovl;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      first_in = first_ff;
      last_in = last_ff;
      wr_in = wr_ff;
      ins_in = ins_ff;
      done_ins_in = done_ins_ff;
      hit_in = hit_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      tail = head;
      shift = 1'b0;
      req_ready = state_ff == S_IDLE && !rsp_valid_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) state_in = S_RESOLVE;
         end
         S_RESOLVE: begin
            cnt_in = '0;
            hit_in = '0;
            done_ins_in = 1'b0;
            ins_in = 1'b0;
            rsp_in = '0;
            if (len == 66'sd0) begin
               first_in = s[62:0];
               last_in = EOF_MARK;
            end else if (len > 66'sd0) begin
               first_in = s[62:0];
               last_in = e_pos[62:0];
            end else begin
               first_in = f_neg[62:0];
               last_in = l_neg[62:0];
            end
            if (req_ff.kind == KIND_REL_ALL || req_ff.kind == KIND_REL_FILE) begin
               state_in = S_UPDATE;
            end else if (!range_ok ||
                         (req_ff.kind == KIND_SET && req_ff.lock_type == LT_BAD)) begin
               rsp_in.status = ST_INVAL;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else if (req_ff.kind == KIND_SET && req_ff.lock_type == LT_UNLOCK) begin
               state_in = S_UPDATE;
            end else begin
               wr_in = (req_ff.kind == KIND_QUERY) ?
                       (req_ff.lock_type == LT_WRITE || req_ff.lock_type == LT_UNLOCK) :
                       (req_ff.lock_type == LT_WRITE);
               state_in = S_SEEK;
            end
         end
         S_SEEK: begin
            shift = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (!hit_ff.conflict_found && same && !own && ovl && (wr_ff || head.is_write)) begin
               hit_in.conflict_found = 1'b1;
               hit_in.conflict_is_write = head.is_write;
               hit_in.conflict_start = head.first;
               hit_in.conflict_len = (head.last == EOF_MARK) ? '0 :
                                     head.last - head.first + 63'd1;
               hit_in.conflict_owner = head.owner;
            end
            if (last_cnt) begin
               cnt_in = '0;
               if (req_ff.kind == KIND_QUERY) begin
                  rsp_in = hit_in;
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end else if (hit_in.conflict_found) begin
                  rsp_in.status = ST_BLOCK;
                  rsp_valid_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  ins_in = 1'b1;
                  state_in = S_UPDATE;
               end
            end
         end
         S_UPDATE: begin
            shift = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (drop) tail.valid = 1'b0;
            // lowest slot free after the removal takes the new lock
            if (ins_ff && !done_ins_ff && (!head.valid || drop)) begin
               tail.valid = 1'b1;
               tail.dev = req_ff.file_dev;
               tail.ino = req_ff.file_ino;
               tail.owner = req_ff.owner;
               tail.is_write = wr_ff;
               tail.first = first_ff;
               tail.last = last_ff;
               done_ins_in = 1'b1;
            end
            if (last_cnt) begin
               cnt_in = '0;
               rsp_in.status = (ins_ff && !done_ins_in) ? ST_FULL : ST_OK;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req;
      first_ff <= first_in;
      last_ff <= last_in;
      wr_ff <= wr_in;
      ins_ff <= ins_in;
      done_ins_ff <= done_ins_in;
      hit_ff <= hit_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

/* hw/rtl/rlt_checker.sv */
// port-level checks for the record lock table, bound to the top level
// depends on rlt_pkg and the record_lock_table ports
module rlt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic        rsp_conflict_found,
   input logic [31:0] rsp_conflict_owner
);
   import rlt_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result beat dropped or changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("request taken while another is in flight");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_conflict_found |-> rsp_status == ST_OK)
      else $error("conflict reported with error status");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_conflict_found |-> rsp_conflict_owner == 32'd0)
      else $error("conflict fields not cleared");

endmodule

bind record_lock_table rlt_checker u_rlt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_conflict_found (rsp_conflict_found),
   .rsp_conflict_owner (rsp_conflict_owner)
);
